/* hw/rtl/bfshd_pkg.sv */
package bfshd_pkg;

    // default graph size and fixed field widths
    localparam int MAX_NODES_DEF  = 32;
    localparam int NODE_W         = 5;
    localparam int NODE_COUNT_W   = 6;
    localparam int DIST_W         = 5;
    localparam int CMD_W          = 2;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 6'd32;
    localparam logic [DIST_W-1:0]       DIST_MAX       = 5'd31;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // control from the sequencer to the adjacency store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } mem_ctl_t;

endpackage

/* hw/rtl/bfshd_adj_store.sv */
module bfshd_adj_store #(
    parameter int MAX_NODES = bfshd_pkg::MAX_NODES_DEF,
    parameter int ADDR_W    = $clog2(MAX_NODES)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bfshd_pkg::mem_ctl_t     ctl,
    input  logic [ADDR_W-1:0]       rd_addr,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic [MAX_NODES-1:0]    wr_data,
    output logic [MAX_NODES-1:0]    rd_data
);

    // one row per vertex, one read and one write port
    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [MAX_NODES-1:0] rd_data_reg;
    logic [MAX_NODES-1:0] row_valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            adj_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= adj_mem[rd_addr];
        end
    end

    // a row never written since reset or clear reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                row_valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/bfs_hop_distance_top.sv */
// hop-distance engine over a small undirected graph held as an adjacency bit
// matrix (one memory row per vertex, reset and the clear command empty it).
// a command beat is taken when start is high and busy is low. add edge sets
// both directions of the edge and gives no result; with both endpoints in use
// it keeps busy high through S_ADD_A and S_ADD_B (read-modify-write of each
// endpoint row), otherwise it is dropped without raising busy. clear graph
// and the unused command code leave busy low and give no result. a query
// gives exactly one result beat: done is high for one cycle with hop_distance
// and reachable, and the receiver cannot hold it off. queries with an endpoint
// outside node_count or with source equal to destination answer in the cycle
// after the command. any other query runs a level-by-level search: each level
// reads rows 0..n-1 through the single memory read port in S_SCAN, then forms
// the next frontier in S_LEVEL; the result beat follows in the cycle after the
// last S_LEVEL, where n is node_count clamped to MAX_NODES. the user must write
// node_count with cfg_write only while the block is idle; the block does not
// enforce this. edges to vertices beyond a shrunk node_count stay stored but
// are never entered. distance saturates at 31 and reads 0 when unreachable.
module bfs_hop_distance_top #(
    parameter int MAX_NODES = bfshd_pkg::MAX_NODES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [bfshd_pkg::NODE_COUNT_W-1:0]  node_count,
    // command side
    input  logic                                start,
    output logic                                busy,
    input  logic [bfshd_pkg::CMD_W-1:0]         command,
    input  logic [bfshd_pkg::NODE_W-1:0]        node_a,
    input  logic [bfshd_pkg::NODE_W-1:0]        node_b,
    // result side
    output logic                                done,
    output logic [bfshd_pkg::DIST_W-1:0]        hop_distance,
    output logic                                reachable
);

    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int WIDE_W = bfshd_pkg::NODE_COUNT_W + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD_A = 3'd1;
    localparam logic [2:0] S_ADD_B = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_LEVEL = 3'd4;

    localparam logic [MAX_NODES-1:0] ONE_ROW = {{(MAX_NODES-1){1'b0}}, 1'b1};

    logic [2:0]                         state_reg, state_next;
    logic [bfshd_pkg::NODE_COUNT_W-1:0] node_count_reg;
    logic [ADDR_W-1:0]                  a_reg, a_next;
    logic [ADDR_W-1:0]                  b_reg, b_next;
    logic [MAX_NODES-1:0]               visited_reg, visited_next;
    logic [MAX_NODES-1:0]               frontier_reg, frontier_next;
    logic [MAX_NODES-1:0]               acc_reg, acc_next;
    logic [ADDR_W-1:0]                  scan_idx_reg, scan_idx_next;
    logic [ADDR_W-1:0]                  pend_row_reg, pend_row_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic [bfshd_pkg::DIST_W-1:0]       level_reg, level_next;
    logic [CNT_W-1:0]                   levels_reg, levels_next;
    logic                               done_reg, done_next;
    logic [bfshd_pkg::DIST_W-1:0]       dist_reg, dist_next;
    logic                               reach_reg, reach_next;

    logic [WIDE_W-1:0]                  n_wide;
    logic [MAX_NODES-1:0]               use_mask;
    logic [MAX_NODES-1:0]               row_data;
    logic [MAX_NODES-1:0]               row_term;
    logic [MAX_NODES-1:0]               new_nodes;
    logic                               a_in_use;
    logic                               b_in_use;
    logic                               accept;

    bfshd_pkg::mem_ctl_t                mem_ctl;
    logic [ADDR_W-1:0]                  rd_addr;
    logic [ADDR_W-1:0]                  wr_addr;
    logic [MAX_NODES-1:0]               wr_data;

    bfshd_adj_store #(
        .MAX_NODES (MAX_NODES),
        .ADDR_W    (ADDR_W)
    ) u_adj_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (row_data)
    );

    // vertex count in effect, clamped to the matrix size
    always_comb
    begin
        if (WIDE_W'(node_count_reg) > WIDE_W'(MAX_NODES))
        begin
            n_wide = WIDE_W'(MAX_NODES);
        end
        else
        begin
            n_wide = WIDE_W'(node_count_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            use_mask[i] = (WIDE_W'(i) < n_wide);
        end
    end

    assign a_in_use = (WIDE_W'(node_a) < n_wide);
    assign b_in_use = (WIDE_W'(node_b) < n_wide);
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;

    // row read last cycle counts only if that vertex is on the frontier
    assign row_term  = (pend_valid_reg && frontier_reg[pend_row_reg]) ? row_data : '0;
    assign new_nodes = (acc_reg | row_term) & use_mask & ~visited_reg;

    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        visited_next    = visited_reg;
        frontier_next   = frontier_reg;
        acc_next        = acc_reg;
        scan_idx_next   = scan_idx_reg;
        pend_row_next   = pend_row_reg;
        pend_valid_next = pend_valid_reg;
        level_next      = level_reg;
        levels_next     = levels_reg;
        done_next       = 1'b0;
        dist_next       = dist_reg;
        reach_next      = reach_reg;
        mem_ctl         = '0;
        rd_addr         = '0;
        wr_addr         = '0;
        wr_data         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    a_next = ADDR_W'(node_a);
                    b_next = ADDR_W'(node_b);
                    case (command)
                        bfshd_pkg::CMD_ADD:
                        begin
                            // out-of-use endpoints leave the graph untouched
                            if (a_in_use && b_in_use)
                            begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = ADDR_W'(node_a);
                                state_next    = S_ADD_A;
                            end
                        end
                        bfshd_pkg::CMD_QUERY:
                        begin
                            visited_next = '0;
                            frontier_next = '0;
                            level_next   = '0;
                            levels_next  = '0;
                            if (!a_in_use || !b_in_use)
                            begin
                                done_next  = 1'b1;
                                dist_next  = '0;
                                reach_next = 1'b0;
                            end
                            else if (node_a == node_b)
                            begin
                                done_next  = 1'b1;
                                dist_next  = '0;
                                reach_next = 1'b1;
                            end
                            else
                            begin
                                visited_next    = ONE_ROW << ADDR_W'(node_a);
                                frontier_next   = ONE_ROW << ADDR_W'(node_a);
                                acc_next        = '0;
                                scan_idx_next   = '0;
                                pend_valid_next = 1'b0;
                                state_next      = S_SCAN;
                            end
                        end
                        bfshd_pkg::CMD_CLEAR:
                        begin
                            mem_ctl.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_ADD_A:
            begin
                // row a arrives now; read row b with the old contents
                mem_ctl.wr_en = 1'b1;
                wr_addr       = a_reg;
                wr_data       = row_data | (ONE_ROW << b_reg);
                mem_ctl.rd_en = 1'b1;
                rd_addr       = b_reg;
                state_next    = S_ADD_B;
            end

            S_ADD_B:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = b_reg;
                wr_data       = row_data | (ONE_ROW << a_reg);
                state_next    = S_IDLE;
            end

            S_SCAN:
            begin
                mem_ctl.rd_en   = 1'b1;
                rd_addr         = scan_idx_reg;
                acc_next        = acc_reg | row_term;
                pend_row_next   = scan_idx_reg;
                pend_valid_next = 1'b1;
                scan_idx_next   = scan_idx_reg + 1'b1;
                if (WIDE_W'(scan_idx_reg) == n_wide - 1'b1)
                begin
                    state_next = S_LEVEL;
                end
            end

            S_LEVEL:
            begin
                if (new_nodes == '0)
                begin
                    done_next  = 1'b1;
                    dist_next  = '0;
                    reach_next = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    levels_next   = levels_reg + 1'b1;
                    level_next    = (level_reg == bfshd_pkg::DIST_MAX) ?
                                    level_reg : level_reg + 1'b1;
                    visited_next  = visited_reg | new_nodes;
                    frontier_next = new_nodes;
                    if (new_nodes[b_reg])
                    begin
                        done_next  = 1'b1;
                        dist_next  = (level_reg == bfshd_pkg::DIST_MAX) ?
                                     level_reg : level_reg + 1'b1;
                        reach_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (WIDE_W'(levels_reg) + 1'b1 >= n_wide)
                    begin
                        done_next  = 1'b1;
                        dist_next  = '0;
                        reach_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        acc_next        = '0;
                        scan_idx_next   = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= bfshd_pkg::NODE_COUNT_RST;
            a_reg          <= '0;
            b_reg          <= '0;
            visited_reg    <= '0;
            frontier_reg   <= '0;
            acc_reg        <= '0;
            scan_idx_reg   <= '0;
            pend_row_reg   <= '0;
            pend_valid_reg <= 1'b0;
            level_reg      <= '0;
            levels_reg     <= '0;
            done_reg       <= 1'b0;
            dist_reg       <= '0;
            reach_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_write)
            begin
                node_count_reg <= node_count;
            end
            a_reg          <= a_next;
            b_reg          <= b_next;
            visited_reg    <= visited_next;
            frontier_reg   <= frontier_next;
            acc_reg        <= acc_next;
            scan_idx_reg   <= scan_idx_next;
            pend_row_reg   <= pend_row_next;
            pend_valid_reg <= pend_valid_next;
            level_reg      <= level_next;
            levels_reg     <= levels_next;
            done_reg       <= done_next;
            dist_reg       <= dist_next;
            reach_reg      <= reach_next;
        end
    end

    assign done         = done_reg;
    assign hop_distance = dist_reg;
    assign reachable    = reach_reg;

    // result beats come only from an accepted command or a running search
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept) || $past(busy))
        else $error("result beat without a command");

    // an unreachable result carries zero distance
    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !reachable) |-> (hop_distance == '0))
        else $error("unreachable result with nonzero distance");

    // the graph is only written during an add sequence
    a_write_in_add: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> (state_reg == S_ADD_A || state_reg == S_ADD_B))
        else $error("adjacency write outside add");

    // frontier is always part of the visited set while searching
    a_frontier_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((frontier_reg & ~visited_reg) == '0))
        else $error("frontier vertex not marked visited");

endmodule

/* tb/bfs_hop_distance_top_test.sv */
`timescale 1ns / 100ps

module bfs_hop_distance_top_test;

    // the one command code the block takes and drops
    localparam logic [bfshd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // answer of one query beat
    typedef struct packed {
        logic [bfshd_pkg::DIST_W-1:0] hops;
        logic                         reach;
    } hop_answer_t;

    // shadow of the adjacency matrix and the queue of query answers still owed
    class hop_tracker;
        logic [31:0]                        rows [32];
        logic [bfshd_pkg::NODE_COUNT_W-1:0] count_setting;
        hop_answer_t                        pending_hops [$];
        int                                 errors;
        int                                 beats;
        int                                 queries;
        int                                 reached;
        int                                 longest;
        int                                 settings;

        function new();
            foreach (rows[r])
                rows[r] = '0;
            count_setting = bfshd_pkg::NODE_COUNT_RST;
            errors = 0;
            beats = 0;
            queries = 0;
            reached = 0;
            longest = 0;
            settings = 0;
        endfunction

        function int active_count();
            return (count_setting > 32) ? 32 : int'(count_setting);
        endfunction

        function void set_node_count(logic [bfshd_pkg::NODE_COUNT_W-1:0] v);
            count_setting = v;
            settings++;
        endfunction

        function int pending();
            return pending_hops.size();
        endfunction

        // level-by-level search over the shadow matrix
        function hop_answer_t search_hops(logic [4:0] src, logic [4:0] dst, int n);
            logic [31:0] mask;
            logic [31:0] seen;
            logic [31:0] front;
            logic [31:0] grown;
            logic [4:0]  lvl;
            int          steps;
            hop_answer_t ans;
            ans = '0;
            if (src >= n || dst >= n)
                return ans;
            if (src == dst)
            begin
                ans.reach = 1'b1;
                return ans;
            end
            mask = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
            seen = 32'd1 << src;
            front = seen;
            steps = 0;
            lvl = '0;
            while (front != '0)
            begin
                grown = '0;
                for (int r = 0; r < n; r++)
                    if (front[r])
                        grown |= rows[r];
                grown &= mask & ~seen;
                if (grown == '0)
                    break;
                steps++;
                if (lvl < bfshd_pkg::DIST_MAX)
                    lvl++;
                seen |= grown;
                front = grown;
                if (grown[dst])
                begin
                    ans.hops = lvl;
                    ans.reach = 1'b1;
                    return ans;
                end
                if (steps >= n)
                    break;
            end
            return ans;
        endfunction

        function void note_command(logic [bfshd_pkg::CMD_W-1:0] cmd,
                                   logic [4:0] a, logic [4:0] b);
            int n;
            n = active_count();
            beats++;
            case (cmd)
                bfshd_pkg::CMD_ADD:
                begin
                    if (a < n && b < n)
                    begin
                        rows[a][b] = 1'b1;
                        rows[b][a] = 1'b1;
                    end
                end
                bfshd_pkg::CMD_CLEAR:
                begin
                    foreach (rows[r])
                        rows[r] = '0;
                end
                bfshd_pkg::CMD_QUERY:
                begin
                    pending_hops = {pending_hops, search_hops(a, b, n)};
                    queries++;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [bfshd_pkg::DIST_W-1:0] hops, logic reach);
            hop_answer_t want;
            if (pending_hops.size() == 0)
            begin
                errors++;
                $display("%0t: result with no query waiting: hop_distance %0d reachable %0b",
                         $time, hops, reach);
                return;
            end
            want = pending_hops.pop_front();
            if (hops !== want.hops)
            begin
                errors++;
                $display("%0t: hop_distance expected %0d actual %0d", $time, want.hops, hops);
            end
            if (reach !== want.reach)
            begin
                errors++;
                $display("%0t: reachable expected %0b actual %0b", $time, want.reach, reach);
            end
            if (want.reach)
                reached++;
            if (int'(want.hops) > longest)
                longest = int'(want.hops);
        endfunction
    endclass

    logic                               clk        = 1'b0;
    logic                               rst_n      = 1'b0;
    logic                               cfg_write  = 1'b0;
    logic [bfshd_pkg::NODE_COUNT_W-1:0] node_count = bfshd_pkg::NODE_COUNT_RST;
    logic                               start      = 1'b0;
    logic                               busy;
    logic [bfshd_pkg::CMD_W-1:0]        command    = bfshd_pkg::CMD_ADD;
    logic [bfshd_pkg::NODE_W-1:0]       node_a     = '0;
    logic [bfshd_pkg::NODE_W-1:0]       node_b     = '0;
    logic                               done;
    logic [bfshd_pkg::DIST_W-1:0]       hop_distance;
    logic                               reachable;

    hop_tracker tracker = new();

    bfs_hop_distance_top #(
        .MAX_NODES (32)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .node_count   (node_count),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .node_a       (node_a),
        .node_b       (node_b),
        .done         (done),
        .hop_distance (hop_distance),
        .reachable    (reachable)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watch both sides at each rising edge; the result is checked before a
    // command taken on the same edge is noted, so answers stay in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_result(hop_distance, reachable);
            if (start && !busy)
                tracker.note_command(command, node_a, node_b);
        end
    end

    // mostly back to back, some short gaps, a few long ones; always back to back when calm
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // a vertex in use most of the time, any index now and then
    function automatic logic [bfshd_pkg::NODE_W-1:0] pick_node(int n);
        if (n == 0 || $urandom_range(0, 9) == 0)
            return bfshd_pkg::NODE_W'($urandom_range(0, 31));
        return bfshd_pkg::NODE_W'($urandom_range(0, n - 1));
    endfunction

    // most settings small so queries stay short, the extremes now and then
    function automatic logic [bfshd_pkg::NODE_COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 6'd0;
        if (r < 10)
            return 6'd1;
        if (r < 15)
            return 6'd32;
        if (r < 18)
            return 6'd63;
        if (r < 20)
            return bfshd_pkg::NODE_COUNT_W'($urandom_range(33, 62));
        if (r < 65)
            return bfshd_pkg::NODE_COUNT_W'($urandom_range(2, 8));
        if (r < 88)
            return bfshd_pkg::NODE_COUNT_W'($urandom_range(9, 20));
        return bfshd_pkg::NODE_COUNT_W'($urandom_range(21, 31));
    endfunction

    // present one command beat and return on the edge that takes it;
    // start is left high so the next beat can follow without a gap
    task automatic send_beat(input logic [bfshd_pkg::CMD_W-1:0] cmd,
                             input logic [bfshd_pkg::NODE_W-1:0] a,
                             input logic [bfshd_pkg::NODE_W-1:0] b, input bit calm);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        node_a  <= a;
        node_b  <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off commands until every owed answer is back
    task automatic wait_answers();
        start <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // node_count only changes with the block idle; an add can still be in
    // its row update after the last answer, so wait until busy is low
    task automatic write_node_count(input logic [bfshd_pkg::NODE_COUNT_W-1:0] v);
        wait_answers();
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_write  <= 1'b1;
        node_count <= v;
        @(posedge clk);
        cfg_write  <= 1'b0;
        tracker.set_node_count(v);
    endtask

    // one phase with a random mix of commands
    task automatic mixed_phase(input int n, input int len, input bit calm);
        int r;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 46)
                send_beat(bfshd_pkg::CMD_ADD, pick_node(n), pick_node(n), calm);
            else if (r < 92)
                send_beat(bfshd_pkg::CMD_QUERY, pick_node(n), pick_node(n), calm);
            else if (r < 94)
                send_beat(bfshd_pkg::CMD_CLEAR, pick_node(n), pick_node(n), calm);
            else if (r < 96)
                send_beat(CMD_UNUSED, pick_node(n), pick_node(n), calm);
            else
                send_beat(bfshd_pkg::CMD_W'($urandom_range(0, 3)),
                          bfshd_pkg::NODE_W'($urandom_range(0, 31)),
                          bfshd_pkg::NODE_W'($urandom_range(0, 31)), calm);
            // now and then drain the answers in the middle of a phase
            if ($urandom_range(0, 99) < 3)
                wait_answers();
        end
    endtask

    // one long chain through every vertex in use, then queries along it
    task automatic chain_phase(input int n, input bit calm);
        int order [32];
        int j;
        int tmp;
        int extra;
        int probes;
        for (int i = 0; i < 32; i++)
            order[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        send_beat(bfshd_pkg::CMD_CLEAR, pick_node(n), pick_node(n), calm);
        for (int i = 0; i + 1 < n; i++)
        begin
            if ($urandom_range(0, 1))
                send_beat(bfshd_pkg::CMD_ADD, bfshd_pkg::NODE_W'(order[i]),
                          bfshd_pkg::NODE_W'(order[i + 1]), calm);
            else
                send_beat(bfshd_pkg::CMD_ADD, bfshd_pkg::NODE_W'(order[i + 1]),
                          bfshd_pkg::NODE_W'(order[i]), calm);
        end
        // the far ends give the deepest search
        send_beat(bfshd_pkg::CMD_QUERY, bfshd_pkg::NODE_W'(order[0]),
                  bfshd_pkg::NODE_W'(order[n - 1]), calm);
        send_beat(bfshd_pkg::CMD_QUERY, bfshd_pkg::NODE_W'(order[n - 1]),
                  bfshd_pkg::NODE_W'(order[0]), calm);
        extra = $urandom_range(0, 3);
        for (int i = 0; i < extra; i++)
            send_beat(bfshd_pkg::CMD_ADD, pick_node(n), pick_node(n), calm);
        probes = $urandom_range(8, 16);
        for (int i = 0; i < probes; i++)
            send_beat(bfshd_pkg::CMD_QUERY, pick_node(n), pick_node(n), calm);
    endtask

    initial
    begin
        logic [bfshd_pkg::NODE_COUNT_W-1:0] setting;
        int                                 n;
        bit                                 calm;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full size graph after reset
        send_beat(bfshd_pkg::CMD_ADD,   5'd0,  5'd31, 1'b0);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd0,  5'd31, 1'b0);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd31, 5'd0,  1'b0);
        // self edge and same source and destination
        send_beat(bfshd_pkg::CMD_ADD,   5'd31, 5'd31, 1'b0);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd31, 5'd31, 1'b0);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd7,  5'd7,  1'b0);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd0,  5'd1,  1'b0);
        // short path 1-2-3-0 hanging off 0-31
        send_beat(bfshd_pkg::CMD_ADD,   5'd1,  5'd2,  1'b1);
        send_beat(bfshd_pkg::CMD_ADD,   5'd2,  5'd3,  1'b1);
        send_beat(bfshd_pkg::CMD_ADD,   5'd3,  5'd0,  1'b1);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd1,  5'd31, 1'b1);
        send_beat(CMD_UNUSED,           5'd5,  5'd6,  1'b0);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd2,  5'd0,  1'b0);
        send_beat(bfshd_pkg::CMD_CLEAR, 5'd0,  5'd0,  1'b0);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd0,  5'd31, 1'b0);
        // edges through vertex 20, which a shrunk graph no longer enters
        send_beat(bfshd_pkg::CMD_ADD,   5'd0,  5'd3,  1'b0);
        send_beat(bfshd_pkg::CMD_ADD,   5'd1,  5'd20, 1'b0);
        send_beat(bfshd_pkg::CMD_ADD,   5'd20, 5'd2,  1'b0);
        write_node_count(6'd4);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd1,  5'd2,  1'b0);
        send_beat(bfshd_pkg::CMD_ADD,   5'd0,  5'd5,  1'b0);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd0,  5'd3,  1'b0);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd4,  5'd4,  1'b0);
        // no vertex in use at all
        write_node_count(6'd0);
        send_beat(bfshd_pkg::CMD_ADD,   5'd0,  5'd0,  1'b0);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd0,  5'd0,  1'b0);
        // count above the matrix size clamps to the full graph
        write_node_count(6'd63);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd1,  5'd2,  1'b0);
        send_beat(bfshd_pkg::CMD_QUERY, 5'd3,  5'd0,  1'b0);

        // random phases, each under its own node_count
        while (tracker.beats < 1750)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 20)
            begin
                setting = ($urandom_range(0, 9) < 4) ? 6'd32
                        : bfshd_pkg::NODE_COUNT_W'($urandom_range(2, 20));
                write_node_count(setting);
                chain_phase(tracker.active_count(), calm);
            end
            else
            begin
                setting = pick_count();
                write_node_count(setting);
                n = tracker.active_count();
                if ($urandom_range(0, 1))
                    send_beat(bfshd_pkg::CMD_CLEAR, pick_node(n), pick_node(n), calm);
                mixed_phase(n, $urandom_range(20, 60), calm);
            end
        end

        wait_answers();
        repeat (30) @(posedge clk);

        if (tracker.pending() != 0)
            $display("%0t: %0d query answers never arrived", $time, tracker.pending());
        $display("covered %0d command beats, %0d queries (%0d reachable, longest %0d hops)",
                 tracker.beats, tracker.queries, tracker.reached, tracker.longest);
        $display("across %0d node_count settings from an empty graph to past full size",
                 tracker.settings);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("bfs_hop_distance_top test passed");
        else
            $display("bfs_hop_distance_top test failed");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #(40_000_000);
        $display("bfs_hop_distance_top test failed");
        $finish;
    end

endmodule
